// ===== hdl/aos_pkg.sv =====
// Shared types, constants and field helpers for the ADC oversampling sequencer.
// No dependencies; used by aos_regs, adc_oversampling_sequencer_top and the testbench.
package aos_pkg;

    localparam int SLOTS_DEF  = 8;
    localparam int WINDOW_DEF = 2;
    localparam int REG_SLOTS  = 8;
    localparam int MAX_EXTRA  = 6;
    localparam int QUEUE_LAG  = 2;

    localparam int SAMPLE_W   = 10;
    localparam int ACC_W      = 22;
    localparam int LEFT_W     = 13;
    localparam int PERIOD_W   = 8;
    localparam int VALUE_W    = 16;
    localparam int CHAN_W     = 3;
    localparam int RES_W      = 3;
    localparam int MASK_W     = 4;
    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 24;
    localparam int OUT_USER_W = 3;
    localparam int REG_ADDR_W = 4;
    localparam int REG_DATA_W = 32;

    typedef enum logic [1:0] {
        REG_ENABLE      = 2'd0,
        REG_CHANNELS    = 2'd1,
        REG_RESOLUTIONS = 2'd2,
        REG_SKIP_MASKS  = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic [REG_SLOTS-1:0]          enable;
        logic [REG_SLOTS*CHAN_W-1:0]   channels;
        logic [REG_SLOTS*RES_W-1:0]    resolutions;
        logic [REG_SLOTS*MASK_W-1:0]   skip_masks;
    } t_cfg;

    // resolution of a slot, saturated at MAX_EXTRA; slots past the registers read 0
    function automatic logic [RES_W-1:0] f_res(input logic [REG_SLOTS*RES_W-1:0] bits,
                                               input logic [3:0] slot);
        logic [RES_W-1:0] r;
        r = RES_W'(bits >> (5'(slot[2:0]) * 5'd3));
        if (slot[3]) begin
            r = '0;
        end else if (r > RES_W'(MAX_EXTRA)) begin
            r = RES_W'(MAX_EXTRA);
        end
        return r;
    endfunction

    function automatic logic [CHAN_W-1:0] f_chan(input logic [REG_SLOTS*CHAN_W-1:0] bits,
                                                 input logic [3:0] slot);
        logic [CHAN_W-1:0] c;
        c = CHAN_W'(bits >> (5'(slot[2:0]) * 5'd3));
        if (slot[3]) begin
            c = '0;
        end
        return c;
    endfunction

    function automatic logic [MASK_W-1:0] f_mask(input logic [REG_SLOTS*MASK_W-1:0] bits,
                                                 input logic [3:0] slot);
        logic [MASK_W-1:0] m;
        m = MASK_W'(bits >> {slot[2:0], 2'b00});
        if (slot[3]) begin
            m = '0;
        end
        return m;
    endfunction

    // 4^res samples per measurement
    function automatic logic [LEFT_W-1:0] f_left(input logic [RES_W-1:0] res);
        return LEFT_W'(LEFT_W'(1) << (4'(res) * 4'(QUEUE_LAG)));
    endfunction

endpackage

// ===== hdl/aos_regs.sv =====
// APB register file for the ADC oversampling sequencer.
// Also flags slots that must restart their accumulation. Depends on aos_pkg.
module aos_regs
    import aos_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [REG_ADDR_W-1:0] paddr,
    input  logic [REG_DATA_W-1:0] pwdata,
    output logic [REG_DATA_W-1:0] prdata,
    output logic                  pready,
    output t_cfg                  o_cfg,
    output logic [REG_SLOTS-1:0]  o_restart
);

    t_cfg                 r_cfg;
    t_reg_idx             w_idx;
    logic                 w_wr;
    logic [REG_SLOTS-1:0] w_res_chg;

    assign w_idx  = t_reg_idx'(paddr[3:2]);
    assign w_wr   = psel & penable & pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_comb begin
        for (int s = 0; s < REG_SLOTS; s++) begin
            w_res_chg[s] = f_res(pwdata[REG_SLOTS*RES_W-1:0], 4'(s))
                           != f_res(r_cfg.resolutions, 4'(s));
        end
    end

    always_comb begin
        o_restart = '0;
        if (w_wr) begin
            case (w_idx)
                REG_ENABLE:      o_restart = pwdata[REG_SLOTS-1:0] & ~r_cfg.enable;
                REG_RESOLUTIONS: o_restart = w_res_chg;
                default:         o_restart = '0;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_ENABLE:      prdata = REG_DATA_W'(r_cfg.enable);
            REG_CHANNELS:    prdata = REG_DATA_W'(r_cfg.channels);
            REG_RESOLUTIONS: prdata = REG_DATA_W'(r_cfg.resolutions);
            REG_SKIP_MASKS:  prdata = REG_DATA_W'(r_cfg.skip_masks);
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (w_wr) begin
            case (w_idx)
                REG_ENABLE:      r_cfg.enable      <= pwdata[REG_SLOTS-1:0];
                REG_CHANNELS:    r_cfg.channels    <= pwdata[REG_SLOTS*CHAN_W-1:0];
                REG_RESOLUTIONS: r_cfg.resolutions <= pwdata[REG_SLOTS*RES_W-1:0];
                REG_SKIP_MASKS:  r_cfg.skip_masks  <= pwdata[REG_SLOTS*MASK_W-1:0];
                default:         r_cfg <= r_cfg;
            endcase
        end
    end

endmodule

// ===== hdl/adc_oversampling_sequencer_top.sv =====
// ADC oversampling and decimation sequencer, top level.
// Holds the sequencer, the slot accumulator memory and the queue; uses aos_pkg, aos_regs.
//
// Each input beat is one finished conversion; it is credited to the slot queued WINDOW
// beats earlier and one output beat follows with the channel to convert next and any
// finished measurement. An item passes through acceptance, the accumulate step, the slot
// scan and the output load; the scan visits one slot per clock and is skipped when no
// slot is enabled, its length depends on the skip masks, and the result may wait for
// the output register to free. Accumulators live in a single-port synchronous RAM read
// on acceptance and written back once; per-slot fresh flags stand for a cleared entry,
// so no clearing pass is needed after reset. The next beat may be accepted while an
// output beat waits.
module adc_oversampling_sequencer_top
    import aos_pkg::*;
#(
    parameter int SLOTS  = SLOTS_DEF,
    parameter int WINDOW = WINDOW_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // [9:0] sample
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,   // [2:0] next_channel, [5:3] done_slot,
                                                  // [21:6] value, [23:22] zero
    output logic [OUT_USER_W-1:0] m_axis_tuser,   // [0] next_is_ground, [1] sample_used,
                                                  // [2] done_res
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [REG_ADDR_W-1:0] paddr,
    input  logic [REG_DATA_W-1:0] pwdata,
    output logic [REG_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int SLOT_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int ENTRY_W = ACC_W + LEFT_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_ACC,
        S_SCAN,
        S_FIN
    } t_state;

    t_cfg                 w_cfg;
    logic [REG_SLOTS-1:0] w_restart8;
    logic [SLOTS-1:0]     w_restart;
    logic [SLOTS-1:0]     w_en;

    t_state               r_state;
    logic [SAMPLE_W-1:0]  r_sample;
    logic [PERIOD_W-1:0]  r_period;
    logic [SLOT_W-1:0]    r_pos;
    logic [SLOT_W-1:0]    r_pend_slot  [WINDOW];
    logic                 r_pend_valid [WINDOW];
    logic [SLOTS-1:0]     r_fresh;
    logic [ENTRY_W-1:0]   r_mem [SLOTS];
    logic [ENTRY_W-1:0]   r_rd_data;
    logic                 r_found_valid;
    logic [SLOT_W-1:0]    r_found;
    logic                 r_used;
    logic                 r_done;
    logic [CHAN_W-1:0]    r_done_slot;
    logic [VALUE_W-1:0]   r_value;
    logic                 r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;
    logic [OUT_USER_W-1:0] r_out_user;

    logic [SLOT_W-1:0]    w_pslot;
    logic                 w_pend_on;
    logic [RES_W-1:0]     w_res;
    logic [ACC_W-1:0]     w_acc;
    logic [LEFT_W-1:0]    w_left;
    logic [ACC_W-1:0]     w_new_acc;
    logic [LEFT_W-1:0]    w_new_left;
    logic                 w_take;
    logic                 w_fin;
    logic [3:0]           w_res2;
    logic [VALUE_W-1:0]   w_value;
    logic                 w_hit;
    logic                 w_wrap;
    logic                 w_load;
    logic [CHAN_W-1:0]    w_next_chan;

    aos_regs u_regs (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .o_cfg     (w_cfg),
        .o_restart (w_restart8)
    );

    assign w_restart = SLOTS'(w_restart8);
    assign w_en      = SLOTS'(w_cfg.enable);

    // accumulate step for the slot at the head of the queue
    assign w_pslot    = r_pend_slot[0];
    assign w_pend_on  = r_pend_valid[0] && w_en[w_pslot];
    assign w_res      = f_res(w_cfg.resolutions, 4'(w_pslot));
    assign w_acc      = r_fresh[w_pslot] ? '0 : r_rd_data[ENTRY_W-1:LEFT_W];
    assign w_left     = r_fresh[w_pslot] ? f_left(w_res) : r_rd_data[LEFT_W-1:0];
    assign w_take     = w_pend_on && (w_left != '0);
    assign w_new_acc  = w_acc + ACC_W'(r_sample);
    assign w_new_left = w_left - LEFT_W'(1);
    assign w_fin      = (w_new_left == '0);
    assign w_res2     = {w_res, 1'b0};
    assign w_value    = (w_res <= RES_W'(3)) ? VALUE_W'(w_new_acc << (4'd6 - w_res2))
                                             : VALUE_W'(w_new_acc >> (w_res2 - 4'd6));

    // scan step
    assign w_hit  = w_en[r_pos]
                    && ((f_mask(w_cfg.skip_masks, 4'(r_pos)) & r_period[MASK_W-1:0]) == '0);
    assign w_wrap = (r_pos == SLOT_W'(SLOTS - 1));

    assign w_load      = (r_state == S_FIN) && (!r_out_valid || m_axis_tready);
    assign w_next_chan = r_found_valid ? f_chan(w_cfg.channels, 4'(r_found)) : '0;

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_user;

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[w_pslot];
        if (r_state == S_ACC && w_take) begin
            r_mem[w_pslot] <= {w_new_acc, w_new_left};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_period      <= '0;
            r_pos         <= '0;
            r_fresh       <= '1;
            r_out_valid   <= 1'b0;
            r_found_valid <= 1'b0;
            for (int i = 0; i < WINDOW; i++) begin
                r_pend_slot[i]  <= '0;
                r_pend_valid[i] <= 1'b0;
            end
        end else begin
            if (r_out_valid && m_axis_tready && !w_load) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_sample <= s_axis_tdata[SAMPLE_W-1:0];
                        r_state  <= S_ACC;
                    end
                end
                S_ACC: begin
                    r_used      <= w_take;
                    r_done      <= w_take && w_fin;
                    r_done_slot <= (w_take && w_fin) ? CHAN_W'(4'(w_pslot)) : '0;
                    r_value     <= (w_take && w_fin) ? w_value : '0;
                    r_found_valid <= 1'b0;
                    r_state       <= (|w_en) ? S_SCAN : S_FIN;
                end
                S_SCAN: begin
                    if (w_wrap) begin
                        r_pos    <= '0;
                        r_period <= r_period + PERIOD_W'(1);
                    end else begin
                        r_pos <= r_pos + SLOT_W'(1);
                    end
                    if (w_hit) begin
                        r_found       <= r_pos;
                        r_found_valid <= 1'b1;
                        r_state       <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (w_load) begin
                        r_out_valid <= 1'b1;
                        r_out_data  <= {2'b00, r_value, r_done_slot, w_next_chan};
                        r_out_user  <= {r_done, r_used, !r_found_valid};
                        for (int i = 0; i < WINDOW - 1; i++) begin
                            r_pend_slot[i]  <= r_pend_slot[i+1];
                            r_pend_valid[i] <= r_pend_valid[i+1];
                        end
                        r_pend_slot[WINDOW-1]  <= r_found_valid ? r_found : '0;
                        r_pend_valid[WINDOW-1] <= r_found_valid;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
            r_fresh <= ((r_state == S_ACC && w_take)
                        ? ((r_fresh & ~(SLOTS'(1) << w_pslot))
                           | (SLOTS'(w_fin) << w_pslot))
                        : r_fresh) | w_restart;
        end
    end

endmodule

// ===== verif/tb_adc_oversampling_sequencer_top.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for adc_oversampling_sequencer_top: directed and random conversion
// beats, slot scheduling and accumulation predicted in-bench. Depends on aos_pkg and the RTL.
module tb_adc_oversampling_sequencer_top
    import aos_pkg::*;
();

    localparam int SLOT_COUNT     = SLOTS_DEF;
    localparam int QUEUE_DEPTH    = WINDOW_DEF;
    localparam int SCAN_GUARD     = 17 * SLOT_COUNT + 1;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DRAIN_SETTLE   = 4;
    localparam int END_SETTLE     = 200;
    localparam int RANDOM_ITEMS   = 370;
    localparam int FULL_RES_ITEMS = 258;

    typedef struct packed {
        logic [CHAN_W-1:0]  next_channel;
        logic               next_is_ground;
        logic               sample_used;
        logic               done_res;
        logic [2:0]         done_slot;
        logic [VALUE_W-1:0] value;
    } t_report;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;    // [9:0] sample
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;         // [2:0] next_channel, [5:3] done_slot,
                                                 // [21:6] value
    logic [OUT_USER_W-1:0] m_axis_tuser;         // [0] next_is_ground, [1] sample_used,
                                                 // [2] done_res
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [REG_ADDR_W-1:0] paddr = '0;
    logic [REG_DATA_W-1:0] pwdata = '0;
    logic [REG_DATA_W-1:0] prdata;
    logic                  pready;

    // shadow of the sequencer
    logic [7:0]            cfg_enable = '0;
    logic [23:0]           cfg_chan = '0;
    logic [23:0]           cfg_res = '0;
    logic [31:0]           cfg_mask = '0;
    logic [PERIOD_W-1:0]   period_cnt = '0;
    int                    scan_pos = 0;
    int                    pend_slot [QUEUE_DEPTH];
    bit                    pend_vld [QUEUE_DEPTH];
    logic [ACC_W-1:0]      acc_mem [SLOT_COUNT];
    logic [LEFT_W-1:0]     left_mem [SLOT_COUNT];

    t_report               report_q [$];
    int                    src_idle_pct = 0;
    int                    sink_stall_pct = 0;
    int                    errors = 0;
    int                    n_items = 0;
    int                    n_reports = 0;
    int                    n_measurements = 0;
    int                    n_reg_writes = 0;
    int                    idle_cycles = 0;

    adc_oversampling_sequencer_top u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #1 i_clk = ~i_clk;

    function automatic bit slot_on(int s);
        if (s >= SLOT_COUNT || s >= REG_SLOTS) begin
            return 1'b0;
        end
        return cfg_enable[s];
    endfunction

    function automatic int slot_res(int s);
        int r;
        if (s >= REG_SLOTS) begin
            return 0;
        end
        r = int'((cfg_res >> (3 * s)) & 24'd7);
        return (r > MAX_EXTRA) ? MAX_EXTRA : r;
    endfunction

    function automatic logic [CHAN_W-1:0] slot_chan(int s);
        if (s >= REG_SLOTS) begin
            return '0;
        end
        return CHAN_W'(cfg_chan >> (3 * s));
    endfunction

    function automatic logic [MASK_W-1:0] slot_mask(int s);
        if (s >= REG_SLOTS) begin
            return '0;
        end
        return MASK_W'(cfg_mask >> (4 * s));
    endfunction

    task automatic reload_slot(int s);
        if (s < SLOT_COUNT) begin
            acc_mem[s] = '0;
            left_mem[s] = LEFT_W'(1) << (QUEUE_LAG * slot_res(s));
        end
    endtask

    task automatic step_scan(inout int pos);
        pos++;
        if (pos >= SLOT_COUNT) begin
            pos = 0;
            period_cnt++;
        end
    endtask

    task automatic pick_next_slot(output int found);
        int pos;
        bit any;
        any = 1'b0;
        found = -1;
        for (int s = 0; s < SLOT_COUNT; s++) begin
            if (slot_on(s)) begin
                any = 1'b1;
            end
        end
        if (any) begin
            pos = (scan_pos >= SLOT_COUNT) ? 0 : scan_pos;
            for (int g = 0; g < SCAN_GUARD && found < 0; g++) begin
                if (slot_on(pos) && (slot_mask(pos) & period_cnt[MASK_W-1:0]) == '0) begin
                    found = pos;
                end
                step_scan(pos);
            end
            scan_pos = pos;
        end
    endtask

    // credit the sample to the slot queued earlier and schedule the next conversion
    task automatic credit_and_schedule(input logic [SAMPLE_W-1:0] smp);
        int nxt;
        int s;
        int r;
        t_report rep;
        pick_next_slot(nxt);
        rep = '0;
        if (nxt >= 0) begin
            rep.next_channel = slot_chan(nxt);
        end else begin
            rep.next_is_ground = 1'b1;
        end
        if (pend_vld[0] && slot_on(pend_slot[0])) begin
            s = pend_slot[0];
            if (left_mem[s] != '0) begin
                acc_mem[s] = acc_mem[s] + ACC_W'(smp);
                left_mem[s] = left_mem[s] - 1'b1;
                rep.sample_used = 1'b1;
                if (left_mem[s] == '0) begin
                    r = slot_res(s);
                    if (r <= 3) begin
                        rep.value = VALUE_W'(acc_mem[s] << (6 - 2 * r));
                    end else begin
                        rep.value = VALUE_W'(acc_mem[s] >> (2 * r - 6));
                    end
                    rep.done_res = 1'b1;
                    rep.done_slot = 3'(s);
                    reload_slot(s);
                end
            end
        end
        for (int i = 0; i + 1 < QUEUE_DEPTH; i++) begin
            pend_slot[i] = pend_slot[i + 1];
            pend_vld[i] = pend_vld[i + 1];
        end
        pend_vld[QUEUE_DEPTH-1] = (nxt >= 0);
        pend_slot[QUEUE_DEPTH-1] = (nxt >= 0) ? nxt : 0;
        report_q.push_back(rep);
    endtask

    task automatic apply_reg(input t_reg_idx idx, input logic [31:0] val);
        logic [7:0] old_en;
        int old_res [SLOT_COUNT];
        case (idx)
            REG_ENABLE: begin
                old_en = cfg_enable;
                cfg_enable = val[7:0];
                for (int s = 0; s < SLOT_COUNT && s < REG_SLOTS; s++) begin
                    if (cfg_enable[s] && !old_en[s]) begin
                        reload_slot(s);
                    end
                end
            end
            REG_CHANNELS: begin
                cfg_chan = val[23:0];
            end
            REG_RESOLUTIONS: begin
                for (int s = 0; s < SLOT_COUNT; s++) begin
                    old_res[s] = slot_res(s);
                end
                cfg_res = val[23:0];
                for (int s = 0; s < SLOT_COUNT; s++) begin
                    if (slot_res(s) != old_res[s]) begin
                        reload_slot(s);
                    end
                end
            end
            default: begin
                cfg_mask = val;
            end
        endcase
    endtask

    task automatic set_idling(input int src_pct, input int sink_pct);
        src_idle_pct = src_pct;
        sink_stall_pct = sink_pct;
    endtask

    // hold the sender until every outstanding report has been taken
    task automatic wait_for_reports();
        s_axis_tvalid <= 1'b0;
        while (report_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_reg_idx idx, input logic [31:0] val);
        wait_for_reports();
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= REG_ADDR_W'(4 * int'(idx));
        pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        apply_reg(idx, val);
        n_reg_writes++;
    endtask

    task automatic write_all_regs(input logic [7:0] en, input logic [23:0] chan,
                                  input logic [23:0] res, input logic [31:0] mask);
        write_reg(REG_CHANNELS, 32'(chan));
        write_reg(REG_RESOLUTIONS, 32'(res));
        write_reg(REG_SKIP_MASKS, mask);
        write_reg(REG_ENABLE, 32'(en));
    endtask

    task automatic send_sample(input logic [SAMPLE_W-1:0] smp);
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= IN_DATA_W'(smp);
        do @(posedge i_clk); while (!s_axis_tready);
        credit_and_schedule(smp);
        n_items++;
    endtask

    function automatic logic [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(9))
            0: return '0;
            1: return '1;
            default: return SAMPLE_W'($urandom_range(1023));
        endcase
    endfunction

    task automatic check_field(input string name, input int exp_v, input int act_v);
        if (exp_v != act_v) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
            errors++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        t_report exp_r;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            n_reports++;
            if (report_q.size() == 0) begin
                $display("%0t: unexpected output beat, expected none, actual tdata %h tuser %b",
                         $time, m_axis_tdata, m_axis_tuser);
                errors++;
            end else begin
                exp_r = report_q.pop_front();
                if (exp_r.done_res) begin
                    n_measurements++;
                end
                check_field("next_channel", exp_r.next_channel, m_axis_tdata[2:0]);
                check_field("next_is_ground", exp_r.next_is_ground, m_axis_tuser[0]);
                check_field("sample_used", exp_r.sample_used, m_axis_tuser[1]);
                check_field("done_res", exp_r.done_res, m_axis_tuser[2]);
                check_field("done_slot", exp_r.done_slot, m_axis_tdata[5:3]);
                check_field("value", exp_r.value, m_axis_tdata[21:6]);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (psel && penable)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no beat for %0d cycles", $time, idle_cycles);
            $display("tb_adc_oversampling_sequencer_top failed");
            $finish;
        end
    end

    task automatic test_power_up_ground();
        set_idling(0, 0);
        send_sample('0);
        send_sample('1);
    endtask

    // every slot at base resolution: each credited sample is a full measurement
    task automatic test_base_resolution();
        write_all_regs(8'hFF, 24'hFAC688, 24'h000000, 32'h0);
        send_sample('0);
        send_sample('1);
        send_sample(10'h155);
        send_sample(10'h2AA);
        send_sample(10'h001);
        send_sample(10'h200);
    endtask

    // odd mask on slot 0, full mask and saturated resolution on slot 7
    task automatic test_odd_masks_saturation();
        write_all_regs(8'h81, 24'hFAC688, 24'(7 << 21), 32'hF000_0005);
        repeat (5) send_sample(pick_sample());
    endtask

    task automatic test_drop_disabled();
        write_all_regs(8'h01, 24'h000005, 24'h000000, 32'h0);
        send_sample(10'h3FF);
        send_sample(10'h123);
        write_reg(REG_ENABLE, 32'h0);
        send_sample(10'h0F0);
        send_sample(10'h30F);
        write_reg(REG_ENABLE, 32'h1);
        send_sample(10'h2C3);
        send_sample(10'h13C);
    endtask

    task automatic test_resolution_change();
        write_all_regs(8'h04, 24'h000100, 24'(2 << 6), 32'h0);
        repeat (4) send_sample(pick_sample());
        write_reg(REG_RESOLUTIONS, 32'(1 << 6));
        repeat (4) send_sample(pick_sample());
    endtask

    // one slot at a high resolution with full-scale samples; wraps the period counter
    task automatic test_full_resolution();
        set_idling(0, 0);
        write_all_regs(8'h08, 24'(5 << 9), 24'(4 << 9), 32'h0);
        repeat (FULL_RES_ITEMS) send_sample('1);
    endtask

    task automatic test_random_traffic();
        int phase;
        int sent;
        int count;
        logic [7:0] en;
        logic [23:0] chan;
        logic [23:0] res;
        logic [31:0] mask;
        int r;
        phase = 0;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            en = ($urandom_range(7) == 0) ? 8'h00 : 8'($urandom_range(1, 255));
            chan = 24'($urandom());
            res = '0;
            mask = '0;
            for (int s = 0; s < REG_SLOTS; s++) begin
                r = $urandom_range(19);
                res[3*s +: 3] = (r < 16) ? 3'($urandom_range(2)) : (r < 18) ? 3'd3 : 3'd7;
                case ($urandom_range(6))
                    0: mask[4*s +: 4] = 4'h0;
                    1: mask[4*s +: 4] = 4'h1;
                    2: mask[4*s +: 4] = 4'h3;
                    3: mask[4*s +: 4] = 4'h7;
                    4: mask[4*s +: 4] = 4'hF;
                    5: mask[4*s +: 4] = 4'h0;
                    default: mask[4*s +: 4] = 4'($urandom_range(15));
                endcase
            end
            write_all_regs(en, chan, res, mask);
            case (phase % 4)
                0: set_idling(0, 0);
                1: set_idling(71, 0);
                2: set_idling(0, 71);
                default: set_idling(21, 21);
            endcase
            count = $urandom_range(60, 110);
            for (int i = 0; i < count; i++) begin
                send_sample(pick_sample());
                if ($urandom_range(49) == 0) begin
                    wait_for_reports();
                end
            end
            sent += count;
            phase++;
        end
    endtask

    initial begin
        for (int s = 0; s < SLOT_COUNT; s++) begin
            reload_slot(s);
        end
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            pend_slot[i] = 0;
            pend_vld[i] = 1'b0;
        end
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_power_up_ground();
        test_base_resolution();
        test_odd_masks_saturation();
        test_drop_disabled();
        test_resolution_change();
        test_full_resolution();
        test_random_traffic();

        wait_for_reports();
        repeat (END_SETTLE) @(posedge i_clk);
        $display("Run covered %0d conversion beats, %0d output beats, %0d finished measurements,",
                 n_items, n_reports, n_measurements);
        $display("%0d register writes, four idling patterns and %0d errors.",
                 n_reg_writes, errors);
        if (errors == 0 && report_q.size() == 0) begin
            $display("tb_adc_oversampling_sequencer_top passed");
        end else begin
            $display("tb_adc_oversampling_sequencer_top failed");
        end
        $finish;
    end

endmodule
